/* sv/ftsig_pkg.sv */
package ftsig_pkg;

  localparam int SECT_W          = 5;
  localparam int SUM_W           = SECT_W + 1;
  localparam int TRACK_W         = 8;
  localparam int CYL_W           = 7;
  localparam int SIZE_W          = 2;
  localparam int MAX_SECTORS_DEF = 21;

  localparam logic [SECT_W-1:0] SPT_RESET  = 5'd18;
  localparam logic [SECT_W-1:0] STEP_RESET = 5'd1;
  localparam logic [SIZE_W-1:0] SIZE_CODE  = 2'd2;

  // register indexes, byte address 4*i
  localparam logic REG_SPT  = 1'b0;
  localparam logic REG_STEP = 1'b1;

  typedef struct packed {
    logic [SECT_W-1:0] n;     // effective sector count
    logic [SECT_W-1:0] step;  // effective interleave, below n
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_PREP,
    ST_EMIT
  } seq_state_t;

endpackage

/* sv/ftsig_ram.sv */
module ftsig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ftsig_step_unit.sv */
// pos + addend, wrapped into 0..n-1 (one add, one compare, one subtract)
module ftsig_step_unit import ftsig_pkg::*; #(
  parameter int IW = 5
) (
  input  logic [IW-1:0]     pos,
  input  logic [SECT_W-1:0] addend,
  input  logic [SECT_W-1:0] n,
  output logic [IW-1:0]     pos_next
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] wrapped;

  always_comb begin
    sum     = SUM_W'(pos) + SUM_W'(addend);
    wrapped = (sum >= SUM_W'(n)) ? (sum - SUM_W'(n)) : sum;
    pos_next = IW'(wrapped);
  end

endmodule

/* sv/ftsig_seq.sv */
module ftsig_seq import ftsig_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF,
  localparam int IW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TRACK_W-1:0] track_number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CYL_W-1:0]   cylinder,
  output logic               head,
  output logic [SECT_W-1:0]  sector_number,
  output logic [SIZE_W-1:0]  size_code,
  output logic               last_record
);

  seq_state_t state, state_next;

  logic [TRACK_W-1:0]     track;
  logic [IW-1:0]          pos;
  logic [IW-1:0]          pos_next;
  logic [SECT_W-1:0]      sect;
  logic [MAX_SECTORS-1:0] occ;
  logic [IW-1:0]          rd_slot, rd_slot_next;
  logic [SECT_W-1:0]      addend;
  logic [SECT_W-1:0]      rdata;
  logic                   start, placing, load, last;

  ftsig_step_unit #(.IW(IW)) u_unit (
    .pos      (pos),
    .addend   (addend),
    .n        (cfg.n),
    .pos_next (pos_next)
  );

  ftsig_ram #(.WIDTH(SECT_W), .DEPTH(MAX_SECTORS)) u_ram (
    .clk   (clk),
    .we    (placing),
    .waddr (pos),
    .wdata (sect),
    .raddr (rd_slot_next),
    .rdata (rdata)
  );

  assign last      = SUM_W'(rd_slot) == (SUM_W'(cfg.n) - SUM_W'(1));
  assign size_code = SIZE_CODE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    start        = 1'b0;
    placing      = 1'b0;
    load         = 1'b0;
    addend       = SECT_W'(1);
    rd_slot_next = rd_slot;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        rd_slot_next = '0;
        if (in_valid) begin
          start      = 1'b1;
          state_next = ST_BUILD;
        end
      end
      ST_BUILD: begin
        // occupied slot: step by one; free slot: place, then step by interleave
        if (!occ[pos]) begin
          placing = 1'b1;
          addend  = cfg.step;
          if (sect == cfg.n) begin
            state_next = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        load = !out_valid || out_ready;
        if (load) begin
          if (last) begin
            state_next = ST_IDLE;
          end else begin
            rd_slot_next = rd_slot + IW'(1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      track <= track_number;
      pos   <= '0;
      sect  <= SECT_W'(1);
    end else if (state == ST_BUILD) begin
      pos <= pos_next;
      if (placing) begin
        sect <= sect + SECT_W'(1);
      end
    end
    if (load) begin
      cylinder      <= track[TRACK_W-1:1];
      head          <= track[0];
      sector_number <= rdata;
      last_record   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      occ <= '0;
    end else if (placing) begin
      occ[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_slot   <= '0;
      out_valid <= 1'b0;
    end else begin
      rd_slot <= rd_slot_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/floppy_track_sector_id_generator.sv */
// Channel | Dir | Handshake          | Payload
// input   | in  | in_valid/in_ready  | track_number[7:0]
// output  | out | out_valid/out_ready| cylinder[6:0] head sector_number[4:0]
//         |     |                    | size_code[1:0] last_record
// config  | in  | APB psel/penable   | paddr[2:0] pwdata/prdata[31:0]
//
// One track word: accept, then place each sector with occupied slots skipped,
// a read-prime state, then one record per cycle while the output is not stalled.
// The shared step unit (add, wrap compare) sets the build time.
// Reset (rst, sync) loads sectors_per_track=18, interleave_step=1.
// Output stalls hold the current record; in_ready returns after the last
// record is loaded into the output register, even if it is not yet taken.
module floppy_track_sector_id_generator import ftsig_pkg::*; #(
  parameter int MAX_SECTORS = MAX_SECTORS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TRACK_W-1:0] track_number,
  // sector ID records
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CYL_W-1:0]   cylinder,
  output logic               head,
  output logic [SECT_W-1:0]  sector_number,
  output logic [SIZE_W-1:0]  size_code,
  output logic               last_record,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [SECT_W-1:0] sectors_per_track;
  logic [SECT_W-1:0] interleave_step;
  logic [SECT_W-1:0] n_eff;
  logic              wr_en;
  cfg_t              cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register index is paddr[2]; low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sectors_per_track <= SPT_RESET;
      interleave_step   <= STEP_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SPT:  sectors_per_track <= pwdata[SECT_W-1:0];
        REG_STEP: interleave_step   <= pwdata[SECT_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SPT:  prdata = 32'(sectors_per_track);
      REG_STEP: prdata = 32'(interleave_step);
      default:  prdata = '0;
    endcase
  end

  // Sector count: zero reads as one, saturate at table depth.
  // Interleave: clamp to n-1 so a placement step never wraps twice.
  always_comb begin
    n_eff = sectors_per_track;
    if (n_eff == '0) begin
      n_eff = SECT_W'(1);
    end
    if (32'(n_eff) > 32'(MAX_SECTORS)) begin
      n_eff = SECT_W'(MAX_SECTORS);
    end
    cfg.n    = n_eff;
    cfg.step = (interleave_step >= n_eff) ? (n_eff - SECT_W'(1)) : interleave_step;
  end

  ftsig_seq #(.MAX_SECTORS(MAX_SECTORS)) u_seq (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .track_number  (track_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cylinder      (cylinder),
    .head          (head),
    .sector_number (sector_number),
    .size_code     (size_code),
    .last_record   (last_record)
  );

endmodule
